>>> src/bfbt_pkg.sv
// Shared constants, codes and types of the best-fit block table.
package bfbt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int SIZE_BITS   = 24;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
   localparam int POS_BITS    = 6;
   localparam int STATUS_BITS = 2;
   localparam int CMP_BITS    = (POS_BITS > CNT_BITS) ? POS_BITS : CNT_BITS;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_ALLOC  = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NOFIT = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

   typedef logic [SIZE_BITS-1:0] size_type;
   typedef logic [IDX_BITS-1:0]  idx_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic     found;
      idx_type  index;
      size_type size;
   } cand_type;

   typedef struct packed {
      logic     ins_en;
      logic     sub_en;
      idx_type  slot;
      cnt_type  count;
      idx_type  best;
      size_type new_size;
      size_type req;
   } cell_ctrl_type;

endpackage

>>> src/bfbt_req_if.sv
// Request channel of the best-fit block table.
interface bfbt_req_if;
   import bfbt_pkg::*;

   logic                valid;
   logic                ready;
   logic                kind;
   logic [POS_BITS-1:0] position;
   size_type            block_size;
   size_type            request_bytes;

   modport source (output valid, kind, position, block_size, request_bytes, input ready);
   modport sink (input valid, kind, position, block_size, request_bytes, output ready);
endinterface

>>> src/bfbt_rsp_if.sv
// Response channel of the best-fit block table.
interface bfbt_rsp_if;
   import bfbt_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   idx_type                chosen_index;
   size_type               remaining_size;
   cnt_type                entry_count;

   modport source (output valid, status, chosen_index, remaining_size, entry_count,
                   input ready);
   modport sink (input valid, status, chosen_index, remaining_size, entry_count,
                 output ready);
endinterface

>>> src/bfbt_cell.sv
// One table cell: holds a block size and passes the best-fit candidate along.
module bfbt_cell (
   input  logic                    clock,
   input  bfbt_pkg::cell_ctrl_type ctrl,
   input  bfbt_pkg::idx_type       cell_index,
   input  bfbt_pkg::size_type      prev_size,
   input  bfbt_pkg::cand_type      cand_in,
   output bfbt_pkg::size_type      size_out,
   output bfbt_pkg::cand_type      cand_out
);
   import bfbt_pkg::*;

   size_type size_ff, size_in;
   cand_type cand_ff, cand_in_next;
   logic     active;
   logic     fits;

   always_comb begin
      size_in = size_ff;
      if (ctrl.ins_en) begin
         if (cell_index == ctrl.slot) begin
            size_in = ctrl.new_size;
         end else if (cell_index > ctrl.slot && CNT_BITS'(cell_index) <= ctrl.count) begin
            size_in = prev_size;
         end
      end else if (ctrl.sub_en && cell_index == ctrl.best) begin
         size_in = size_ff - ctrl.req;
      end
   end

   assign active = CNT_BITS'(cell_index) < ctrl.count;
   assign fits   = active && size_ff >= ctrl.req && (!cand_in.found || size_ff < cand_in.size);

   always_comb begin
      cand_in_next = cand_in;
      if (fits) begin
         cand_in_next.found = 1'b1;
         cand_in_next.index = cell_index;
         cand_in_next.size  = size_ff;
      end
   end

   always_ff @(posedge clock) begin
      size_ff <= size_in;
      cand_ff <= cand_in_next;
   end

   assign size_out = size_ff;
   assign cand_out = cand_ff;
endmodule

>>> src/bfbt_ctrl.sv
// Sequencer: takes requests, drives the cell row and registers the responses.
module bfbt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   bfbt_req_if.sink                req_chan,
   bfbt_rsp_if.source              rsp_chan,
   input  bfbt_pkg::cand_type      last_cand,
   output bfbt_pkg::cell_ctrl_type cell_ctrl
);
   import bfbt_pkg::*;

   state_type              state_ff, state_in;
   logic                   kind_ff;
   logic [POS_BITS-1:0]    pos_ff;
   size_type               new_size_ff;
   size_type               req_ff;
   cnt_type                count_ff, count_in;
   idx_type                scan_ff, scan_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   idx_type                index_ff, index_in;
   size_type               remain_ff, remain_in;
   cnt_type                entries_ff, entries_in;

   logic                   accept;
   logic                   out_free;
   logic                   full;
   logic [CMP_BITS-1:0]    pos_ext;
   logic [CMP_BITS-1:0]    cnt_ext;
   cnt_type                slot;
   logic                   ins_en;
   logic                   sub_en;
   logic                   load_rsp;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign full     = count_ff == CNT_BITS'(TABLE_DEPTH);
   assign pos_ext  = CMP_BITS'(pos_ff[POS_BITS-2:0]);
   assign cnt_ext  = CMP_BITS'(count_ff);

   always_comb begin
      if (count_ff == '0 || pos_ff[POS_BITS-1]) begin
         slot = '0;
      end else if (pos_ext >= cnt_ext) begin
         slot = count_ff;
      end else begin
         slot = CNT_BITS'(pos_ext + CMP_BITS'(1));
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = (req_chan.kind == KIND_ALLOC) ? ST_SCAN : ST_INSERT;
            end
         end
         ST_INSERT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (scan_ff == IDX_BITS'(TABLE_DEPTH - 1)) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ins_en    = 1'b0;
      sub_en    = 1'b0;
      load_rsp  = 1'b0;
      status_in = status_ff;
      index_in  = index_ff;
      remain_in = remain_ff;
      count_in  = count_ff;
      scan_in   = '0;
      case (state_ff)
         ST_INSERT: begin
            if (out_free) begin
               load_rsp = 1'b1;
               if (full) begin
                  status_in = STATUS_FULL;
                  index_in  = '0;
                  remain_in = '0;
               end else begin
                  ins_en    = 1'b1;
                  count_in  = count_ff + CNT_BITS'(1);
                  status_in = STATUS_DONE;
                  index_in  = slot[IDX_BITS-1:0];
                  remain_in = new_size_ff;
               end
            end
         end
         ST_SCAN: begin
            scan_in = scan_ff + IDX_BITS'(1);
         end
         ST_COMMIT: begin
            if (out_free) begin
               load_rsp = 1'b1;
               if (last_cand.found) begin
                  sub_en    = 1'b1;
                  status_in = STATUS_DONE;
                  index_in  = last_cand.index;
                  remain_in = last_cand.size - req_ff;
               end else begin
                  status_in = STATUS_NOFIT;
                  index_in  = '0;
                  remain_in = '0;
               end
            end
         end
         default: begin
            scan_in = '0;
         end
      endcase
      entries_in   = count_in;
      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff     <= req_chan.kind;
         pos_ff      <= req_chan.position;
         new_size_ff <= req_chan.block_size;
         req_ff      <= req_chan.request_bytes;
      end
      if (load_rsp) begin
         status_ff  <= status_in;
         index_ff   <= index_in;
         remain_ff  <= remain_in;
         entries_ff <= entries_in;
      end
   end

   assign req_chan.ready = state_ff == ST_IDLE;

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.chosen_index   = index_ff;
   assign rsp_chan.remaining_size = remain_ff;
   assign rsp_chan.entry_count    = entries_ff;

   always_comb begin
      cell_ctrl.ins_en   = ins_en && kind_ff == KIND_INSERT;
      cell_ctrl.sub_en   = sub_en && kind_ff == KIND_ALLOC;
      cell_ctrl.slot     = slot[IDX_BITS-1:0];
      cell_ctrl.count    = count_ff;
      cell_ctrl.best     = last_cand.index;
      cell_ctrl.new_size = new_size_ff;
      cell_ctrl.req      = req_ff;
   end
endmodule

>>> src/best_fit_block_table.sv
// Top level of the best-fit block table: sequencer and a row of size cells.
//
// The block keeps an ordered table of up to 16 free block sizes, one per cell.
// Requests arrive on req_chan and each one produces exactly one transfer on
// rsp_chan, in order. An insert places block_size at the front, after the
// entry named by position, or at the end; an allocate picks the smallest
// block not below request_bytes (lowest index on a tie) and reduces it.
// An insert's response is registered as the sequencer leaves its insert state,
// and the next request can be taken once the sequencer is back in idle.
// An allocate sends a candidate down the cell row one cell per cycle; the
// sequencer scans the whole row, registers the response in its commit state
// and takes no new request until it is back in idle.
// The response sits in an output register; while the receiver stalls a
// finished item waits there, and the next request is held before it writes
// the table until that response drains.
// Synchronous reset empties the table and drops any pending response; cell
// contents are not cleared, since only entries below the count are read.
module best_fit_block_table (
   input logic        clock,
   input logic        reset,
   bfbt_req_if.sink   req_chan,
   bfbt_rsp_if.source rsp_chan
);
   import bfbt_pkg::*;

   cell_ctrl_type cell_ctrl;
   size_type      size_q [TABLE_DEPTH];
   cand_type      cand_q [TABLE_DEPTH];
   size_type      prev_q [TABLE_DEPTH];
   cand_type      chain_q [TABLE_DEPTH];

   bfbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .last_cand (cand_q[TABLE_DEPTH-1]),
      .cell_ctrl (cell_ctrl)
   );

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign prev_q[i]  = '0;
         assign chain_q[i] = '0;
      end else begin : g_link
         assign prev_q[i]  = size_q[i-1];
         assign chain_q[i] = cand_q[i-1];
      end

      bfbt_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .cell_index (IDX_BITS'(i)),
         .prev_size  (prev_q[i]),
         .cand_in    (chain_q[i]),
         .size_out   (size_q[i]),
         .cand_out   (cand_q[i])
      );
   end
endmodule

>>> tb/testbench.sv
// Self-checking testbench for the best-fit block table: directed and random traffic.
`timescale 1ns / 100ps

module testbench;
   import bfbt_pkg::*;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      idx_type                index;
      size_type               size;
      cnt_type                count;
   } outcome_type;

   class fit_tracker;
      size_type    sizes[TABLE_DEPTH];
      int unsigned count;
      outcome_type pending_results[$];
      int unsigned mismatches, checked, inserts, allocs, fulls, nofits;

      function void take_request(logic kind, logic [POS_BITS-1:0] position,
                                 size_type block_size, size_type request_bytes);
         outcome_type o;
         int          p;
         int          best;
         int unsigned slot;
         int unsigned i;
         o = '0;
         if (kind == KIND_INSERT) begin
            inserts++;
            if (count >= TABLE_DEPTH) begin
               o.status = STATUS_FULL;
               fulls++;
            end else begin
               p = $signed(position);
               if (p < -1) p = -1;
               if (count == 0 || p == -1) slot = 0;
               else if (p >= int'(count)) slot = count;
               else slot = p + 1;
               for (i = count; i > slot; i--) sizes[i] = sizes[i-1];
               sizes[slot] = block_size;
               count++;
               o.status = STATUS_DONE;
               o.index  = idx_type'(slot);
               o.size   = block_size;
            end
         end else begin
            allocs++;
            best = -1;
            for (i = 0; i < count; i++)
               if (sizes[i] >= request_bytes && (best < 0 || sizes[i] < sizes[best]))
                  best = i;
            if (best < 0) begin
               o.status = STATUS_NOFIT;
               nofits++;
            end else begin
               sizes[best] = sizes[best] - request_bytes;
               o.status = STATUS_DONE;
               o.index  = idx_type'(best);
               o.size   = sizes[best];
            end
         end
         o.count = cnt_type'(count);
         pending_results.push_back(o);
      endfunction

      function void check_response(outcome_type got);
         outcome_type want;
         checked++;
         if (pending_results.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected response: status %0d index %0d size %0d count %0d",
                        got.status, got.index, got.size, got.count);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.index !== want.index ||
                got.size !== want.size || got.count !== want.count) begin
               if (mismatches < 10)
                  $display("mismatch at %0t: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                           $realtime, want.status, want.index, want.size, want.count,
                           got.status, got.index, got.size, got.count);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   quiet = 1'b0;
   int unsigned stall_cycles = 0;
   fit_tracker tracker = new();

   bfbt_req_if req_bus();
   bfbt_rsp_if rsp_bus();

   best_fit_block_table uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic send_op(input logic kind, input logic [POS_BITS-1:0] position,
                          input size_type block_size, input size_type request_bytes);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.kind          <= kind;
      req_bus.position      <= position;
      req_bus.block_size    <= block_size;
      req_bus.request_bytes <= request_bytes;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      tracker.take_request(kind, position, block_size, request_bytes);
   endtask

   task automatic random_op();
      logic                kind;
      logic [POS_BITS-1:0] position;
      size_type            block_size, request_bytes, pick, largest;
      int unsigned         r, i;
      block_size    = size_type'($urandom());
      request_bytes = size_type'($urandom());
      position      = POS_BITS'($urandom());
      if (tracker.count < TABLE_DEPTH)
         kind = ($urandom_range(0, 9) < 6) ? KIND_INSERT : KIND_ALLOC;
      else
         kind = ($urandom_range(0, 9) == 0) ? KIND_INSERT : KIND_ALLOC;
      if (kind == KIND_INSERT) begin
         r = $urandom_range(0, 9);
         if (r == 2) position = '1;
         else if (r == 3) position = POS_BITS'(tracker.count);
         else if (r > 3) position = POS_BITS'($urandom_range(0, tracker.count));
         r = $urandom_range(0, 9);
         if (r < 3) block_size = size_type'($urandom_range(0, 16));
         else if (r == 3) block_size = '1;
      end else if (tracker.count != 0) begin
         pick = tracker.sizes[$urandom_range(0, tracker.count - 1)];
         largest = '0;
         for (i = 0; i < tracker.count; i++)
            if (tracker.sizes[i] > largest) largest = tracker.sizes[i];
         case ($urandom_range(0, 9))
            0: ;
            1: request_bytes = '0;
            2: request_bytes = pick;
            3: request_bytes = pick + 1'b1;
            4, 5: request_bytes = size_type'($urandom_range(0, largest));
            default: request_bytes = size_type'($urandom_range(0, pick));
         endcase
      end
      send_op(kind, position, block_size, request_bytes);
   endtask

   initial begin
      req_bus.valid         <= 1'b0;
      req_bus.kind          <= KIND_INSERT;
      req_bus.position      <= '0;
      req_bus.block_size    <= '0;
      req_bus.request_bytes <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_op(KIND_ALLOC,  6'd0,  24'd0,       24'd5);
      send_op(KIND_INSERT, 6'd31, 24'd100,     24'hFFFFFF);
      send_op(KIND_INSERT, 6'h3F, 24'd50,      24'd0);
      send_op(KIND_INSERT, 6'h20, 24'hFFFFFF,  24'd0);
      send_op(KIND_INSERT, 6'd0,  24'd100,     24'd0);
      send_op(KIND_INSERT, 6'd16, 24'd7,       24'd0);
      send_op(KIND_INSERT, 6'd4,  24'd0,       24'd0);
      send_op(KIND_INSERT, 6'd2,  24'd100,     24'd0);
      send_op(KIND_ALLOC,  6'h3F, 24'hFFFFFF,  24'd100);
      send_op(KIND_ALLOC,  6'd0,  24'd0,       24'd0);
      send_op(KIND_ALLOC,  6'd0,  24'd0,       24'hFFFFFF);
      send_op(KIND_ALLOC,  6'd0,  24'd0,       24'hFFFFFF);
      send_op(KIND_ALLOC,  6'd0,  24'd0,       24'd8);
      send_op(KIND_INSERT, 6'd0,  24'd0,       24'd0);
      send_op(KIND_INSERT, 6'd62, 24'd3,       24'd0);

      for (int n = 0; n < 1735; n++) begin
         if (n == 1435) quiet = 1'b1;
         random_op();
      end
      req_bus.valid <= 1'b0;

      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Covered %0d inserts (%0d on a full table) and %0d allocations (%0d %s).",
               tracker.inserts, tracker.fulls, tracker.allocs, tracker.nofits,
               "without a fit");
      $display("Checked %0d responses, %0d mismatches.", tracker.checked, tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         tracker.check_response({rsp_bus.status, rsp_bus.chosen_index,
                                 rsp_bus.remaining_size, rsp_bus.entry_count});
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= 2000) begin
         $display("Timeout: no transfer for %0d cycles.", stall_cycles);
         $display("simulation failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
